// ----- sv/ppb_pkg.sv -----
// ============================================================================
// ppb_pkg: shared definitions for the priority push-out buffer
// Field widths, event and mode codes, and the controller/datapath link types.
// ============================================================================
`default_nettype none

package ppb_pkg;

    localparam int NUM_PRIORITIES_DEF = 3;
    localparam int QUEUE_DEPTH_DEF    = 16;

    localparam int MODE_W  = 2;
    localparam int PRIO_W  = 2;
    localparam int TAG_W   = 16;
    localparam int LEN_W   = 16;
    localparam int EV_W    = 3;
    localparam int MOVED_W = 5;
    localparam int S2B_W   = 21;
    localparam int SIZE_W  = 32;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP_ANY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POP_GIVEN = 2'd3;

    localparam logic [EV_W-1:0] EV_ACCEPTED  = 3'd0;
    localparam logic [EV_W-1:0] EV_DROPPED   = 3'd1;
    localparam logic [EV_W-1:0] EV_POPPED    = 3'd2;
    localparam logic [EV_W-1:0] EV_FORWARDED = 3'd3;
    localparam logic [EV_W-1:0] EV_NOTHING   = 3'd4;
    localparam logic [EV_W-1:0] EV_REJECTED  = 3'd5;

    localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 32'd1048576;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word
        logic rd;     // read the front entry of the selected class
        logic take;   // remove the read entry and report it
        logic fin;    // finish the word with its closing result
    } ppb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              need_drop;
        logic              pick_ok;
        logic              out_free;
    } ppb_stat_t;

endpackage

`default_nettype wire

// ----- sv/ppb_ram.sv -----
// ============================================================================
// ppb_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; read data holds without enable.
// ============================================================================
`default_nettype none

module ppb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ppb_ctrl.sv -----
// ============================================================================
// ppb_ctrl: sequencing controller of the priority push-out buffer
// Steps one word through decision, push-out reads and its closing result.
// ============================================================================
`default_nettype none

module ppb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ppb_pkg::ppb_stat_t stat,
    output ppb_pkg::ppb_cmd_t      cmd
);
    import ppb_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_FINAL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // An insert loops here once per push-out drop.
                if (stat.mode == MODE_INSERT)
                begin
                    if (stat.need_drop)
                    begin
                        cmd.rd     = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
                else if (stat.mode == MODE_FORWARD)
                begin
                    state_next = S_FINAL;
                end
                else if (stat.pick_ok)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.take   = 1'b1;
                    state_next = (stat.mode == MODE_INSERT) ? S_DECIDE : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ($past(state_reg) == S_DECIDE || $past(state_reg) == S_READ))
        else $error("read state entered without a decision");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take || cmd.fin) |-> stat.out_free)
        else $error("result issued while the output register is occupied");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd, cmd.take, cmd.fin}))
        else $error("more than one command in a cycle");

endmodule

`default_nettype wire

// ----- sv/ppb_dp.sv -----
// ============================================================================
// ppb_dp: datapath of the priority push-out buffer
// Per-class queue counters, descriptor RAM, decision logic and result register.
// ============================================================================
`default_nettype none

module ppb_dp #(
    parameter int NUM_PRIORITIES = ppb_pkg::NUM_PRIORITIES_DEF,
    parameter int QUEUE_DEPTH    = ppb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ppb_pkg::ppb_cmd_t             cmd,
    output ppb_pkg::ppb_stat_t                 stat,
    input  wire logic                          cfg_we,
    input  wire logic [ppb_pkg::SIZE_W-1:0]    cfg_wdata,
    input  wire logic [ppb_pkg::MODE_W-1:0]    mode,
    input  wire logic [ppb_pkg::PRIO_W-1:0]    priority_req,
    input  wire logic [ppb_pkg::TAG_W-1:0]     packet_tag,
    input  wire logic [ppb_pkg::LEN_W-1:0]     length_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [ppb_pkg::EV_W-1:0]      event_res,
    output logic      [ppb_pkg::TAG_W-1:0]     tag,
    output logic      [ppb_pkg::PRIO_W-1:0]    class_out,
    output logic      [ppb_pkg::LEN_W-1:0]     bits,
    output logic                               was_stage_two,
    output logic      [ppb_pkg::MOVED_W-1:0]   moved_count,
    output logic      [ppb_pkg::S2B_W-1:0]     stage_two_bits,
    output logic                               last
);
    import ppb_pkg::*;

    localparam int CLS_W = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CB_W  = LEN_W + CNT_W;
    localparam int TOT_W = (CB_W + CLS_W + 2 > SIZE_W + 1) ? CB_W + CLS_W + 2 : SIZE_W + 1;
    localparam int SLOTS = NUM_PRIORITIES * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int RW    = TAG_W + LEN_W;

    logic [SIZE_W-1:0] size_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [PRIO_W-1:0] pr_reg;
    logic [TAG_W-1:0]  ptag_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [CLS_W-1:0]  tclass_reg;

    logic [PTR_W-1:0] head_reg  [NUM_PRIORITIES];
    logic [CNT_W-1:0] cnt_reg   [NUM_PRIORITIES];
    logic [CB_W-1:0]  cbits_reg [NUM_PRIORITIES];
    logic [CNT_W-1:0] s2cnt_reg [NUM_PRIORITIES];
    logic [CB_W-1:0]  s2tot_reg [NUM_PRIORITIES];

    logic                out_valid_reg;
    logic [EV_W-1:0]     ev_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [PRIO_W-1:0]   cls_reg;
    logic [LEN_W-1:0]    bits_reg;
    logic                s2_reg;
    logic [MOVED_W-1:0]  moved_reg;
    logic [S2B_W-1:0]    s2b_reg;
    logic                last_reg;

    // Decision logic.
    logic              pr_ok;
    logic [CLS_W-1:0]  prx;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  below;
    logic              victim_found;
    logic [CLS_W-1:0]  victim;
    logic              pick_found;
    logic [CLS_W-1:0]  pick;
    logic              full;
    logic              out_free;

    assign pr_ok = ({{(32-PRIO_W){1'b0}}, pr_reg} < NUM_PRIORITIES);
    assign prx   = CLS_W'(pr_reg);
    assign full  = (cnt_reg[prx] == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        total        = '0;
        below        = '0;
        victim_found = 1'b0;
        victim       = '0;
        for (int i = 0; i < NUM_PRIORITIES; i++)
        begin
            total = total + TOT_W'(cbits_reg[i]);
            if (i >= int'(pr_reg))
            begin
                below = below + TOT_W'(cbits_reg[i]);
                if (cnt_reg[i] != '0)
                begin
                    victim_found = 1'b1;
                    victim       = CLS_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        pick_found = 1'b0;
        pick       = '0;
        if (mode_reg == MODE_POP_GIVEN)
        begin
            pick_found = pr_ok && (cnt_reg[prx] != '0);
            pick       = prx;
        end
        else
        begin
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                if (!pick_found && s2cnt_reg[i] != '0)
                begin
                    pick_found = 1'b1;
                    pick       = CLS_W'(i);
                end
            end
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                if (!pick_found && cnt_reg[i] != '0)
                begin
                    pick_found = 1'b1;
                    pick       = CLS_W'(i);
                end
            end
        end
    end

    assign out_free       = !out_valid_reg || !out_stall;
    assign stat.mode      = mode_reg;
    assign stat.need_drop = pr_ok && victim_found
                            && (total + TOT_W'(plen_reg) > TOT_W'(size_reg))
                            && (below >= TOT_W'(plen_reg));
    assign stat.pick_ok   = pick_found;
    assign stat.out_free  = out_free;

    // Descriptor memory: tag in the upper half, length in the lower half.
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic [RW-1:0]    rdata;
    logic             ram_we;
    logic [CNT_W:0]   wsum;
    logic [PTR_W-1:0] wptr;
    logic [CLS_W-1:0] rclass;

    assign rclass = (mode_reg == MODE_INSERT) ? victim : pick;
    assign raddr  = AW'(AW'(rclass) * AW'(QUEUE_DEPTH) + AW'(head_reg[rclass]));
    assign wsum   = (CNT_W+1)'(head_reg[prx]) + (CNT_W+1)'(cnt_reg[prx]);
    assign wptr   = (wsum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? PTR_W'(wsum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(wsum);
    assign waddr  = AW'(AW'(prx) * AW'(QUEUE_DEPTH) + AW'(wptr));
    assign ram_we = cmd.fin && (mode_reg == MODE_INSERT) && pr_ok && !full;

    ppb_ram #(
        .WIDTH(RW),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(waddr),
        .wdata({ptag_reg, plen_reg}),
        .re   (cmd.rd),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Removal of the entry just read.
    logic [LEN_W-1:0] t_len;
    logic             t_was2;
    logic [CB_W-1:0]  t_s2new;
    logic [PTR_W-1:0] t_head;

    assign t_len   = rdata[LEN_W-1:0];
    assign t_was2  = (s2cnt_reg[tclass_reg] != '0);
    assign t_s2new = t_was2 ? s2tot_reg[tclass_reg] - CB_W'(t_len) : s2tot_reg[tclass_reg];
    assign t_head  = (head_reg[tclass_reg] == PTR_W'(QUEUE_DEPTH - 1))
                     ? '0 : head_reg[tclass_reg] + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= BUFFER_SIZE_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                head_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                cbits_reg[i] <= '0;
                s2cnt_reg[i] <= '0;
                s2tot_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (cmd.take || cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.take)
            begin
                head_reg[tclass_reg]  <= t_head;
                cnt_reg[tclass_reg]   <= cnt_reg[tclass_reg] - CNT_W'(1);
                cbits_reg[tclass_reg] <= cbits_reg[tclass_reg] - CB_W'(t_len);
                s2tot_reg[tclass_reg] <= t_s2new;
                if (t_was2)
                begin
                    s2cnt_reg[tclass_reg] <= s2cnt_reg[tclass_reg] - CNT_W'(1);
                end
            end
            if (cmd.fin && pr_ok)
            begin
                if (mode_reg == MODE_INSERT && !full)
                begin
                    cnt_reg[prx]   <= cnt_reg[prx] + CNT_W'(1);
                    cbits_reg[prx] <= cbits_reg[prx] + CB_W'(plen_reg);
                end
                else if (mode_reg == MODE_FORWARD)
                begin
                    s2cnt_reg[prx] <= cnt_reg[prx];
                    s2tot_reg[prx] <= cbits_reg[prx];
                end
            end
        end
    end

    // Captured word and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            pr_reg   <= priority_req;
            ptag_reg <= packet_tag;
            plen_reg <= length_bits;
        end
        if (cmd.rd)
        begin
            tclass_reg <= rclass;
        end
        if (cmd.take)
        begin
            ev_reg    <= (mode_reg == MODE_INSERT) ? EV_DROPPED : EV_POPPED;
            tag_reg   <= rdata[RW-1:LEN_W];
            cls_reg   <= PRIO_W'(tclass_reg);
            bits_reg  <= t_len;
            s2_reg    <= t_was2;
            moved_reg <= '0;
            s2b_reg   <= S2B_W'(t_s2new);
            last_reg  <= (mode_reg != MODE_INSERT);
        end
        else if (cmd.fin)
        begin
            last_reg <= 1'b1;
            s2_reg   <= 1'b0;
            case (mode_reg)
                MODE_INSERT:
                begin
                    ev_reg    <= (pr_ok && !full) ? EV_ACCEPTED : EV_REJECTED;
                    tag_reg   <= ptag_reg;
                    cls_reg   <= pr_reg;
                    bits_reg  <= plen_reg;
                    moved_reg <= '0;
                    s2b_reg   <= pr_ok ? S2B_W'(s2tot_reg[prx]) : '0;
                end
                MODE_FORWARD:
                begin
                    ev_reg    <= EV_FORWARDED;
                    tag_reg   <= '0;
                    cls_reg   <= pr_reg;
                    bits_reg  <= '0;
                    moved_reg <= pr_ok ? MOVED_W'(cnt_reg[prx] - s2cnt_reg[prx]) : '0;
                    s2b_reg   <= pr_ok ? S2B_W'(cbits_reg[prx]) : '0;
                end
                default:
                begin
                    // Nothing to pop: pop any reports class zero.
                    ev_reg    <= EV_NOTHING;
                    tag_reg   <= '0;
                    bits_reg  <= '0;
                    moved_reg <= '0;
                    if (mode_reg == MODE_POP_GIVEN)
                    begin
                        cls_reg <= pr_reg;
                        s2b_reg <= pr_ok ? S2B_W'(s2tot_reg[prx]) : '0;
                    end
                    else
                    begin
                        cls_reg <= '0;
                        s2b_reg <= S2B_W'(s2tot_reg[0]);
                    end
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = ev_reg;
    assign tag            = tag_reg;
    assign class_out      = cls_reg;
    assign bits           = bits_reg;
    assign was_stage_two  = s2_reg;
    assign moved_count    = moved_reg;
    assign stage_two_bits = s2b_reg;
    assign last           = last_reg;

    a_s2cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2cnt_reg[0] <= cnt_reg[0])
        else $error("stage-two count exceeds queue occupancy");

    a_s2tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s2tot_reg[0] <= cbits_reg[0])
        else $error("stage-two bits exceed class bits");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

// ----- sv/priority_pushout_two_stage_buffer.sv -----
// From the accepting cycle, an insert with no push-out and a forward step through the
// decision and final states, a pop through the decision and read states (final if
// nothing is found), and each loads its result register at its last step; each push-out
// drop adds a decision, then the registered descriptor read and the drop report.
// Words are handled one at a time; a stalled result register holds the controller.
// Reset (rst_n, asynchronous) empties all queues and sets buffer size to 1048576.
// ============================================================================
// priority_pushout_two_stage_buffer: strict-priority shared packet buffer
// Per-class descriptor FIFOs with push-out drop and a two-stage forward view.
// ============================================================================
`default_nettype none

module priority_pushout_two_stage_buffer #(
    parameter int NUM_PRIORITIES = ppb_pkg::NUM_PRIORITIES_DEF,
    parameter int QUEUE_DEPTH    = ppb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ppb_pkg::SIZE_W-1:0]   cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [ppb_pkg::MODE_W-1:0]   mode,
    input  wire logic [ppb_pkg::PRIO_W-1:0]   priority_req,
    input  wire logic [ppb_pkg::TAG_W-1:0]    packet_tag,
    input  wire logic [ppb_pkg::LEN_W-1:0]    length_bits,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [ppb_pkg::EV_W-1:0]     event_res,
    output logic      [ppb_pkg::TAG_W-1:0]    tag,
    output logic      [ppb_pkg::PRIO_W-1:0]   class_out,
    output logic      [ppb_pkg::LEN_W-1:0]    bits,
    output logic                              was_stage_two,
    output logic      [ppb_pkg::MOVED_W-1:0]  moved_count,
    output logic      [ppb_pkg::S2B_W-1:0]    stage_two_bits,
    output logic                              last
);
    import ppb_pkg::*;

    // The controller walks each word through its steps; the datapath holds the
    // per-class counters, the descriptor RAM and the output register, which
    // lets the controller accept and decide a new word while the previous
    // result still waits. The new result is loaded once that register frees.
    ppb_cmd_t  cmd;
    ppb_stat_t stat;

    ppb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppb_dp #(
        .NUM_PRIORITIES(NUM_PRIORITIES),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .priority_req  (priority_req),
        .packet_tag    (packet_tag),
        .length_bits   (length_bits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .tag           (tag),
        .class_out     (class_out),
        .bits          (bits),
        .was_stage_two (was_stage_two),
        .moved_count   (moved_count),
        .stage_two_bits(stage_two_bits),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ============================================================================
// testbench: self-checking bench for the priority push-out buffer
// Drives insert, forward and pop words through a directed table and random
// traffic, predicts every result word and compares them in arrival order.
// ============================================================================
`default_nettype none

module testbench;

    import ppb_pkg::*;

    localparam int NPRI  = 3;
    localparam int DEPTH = 16;

    // One expected or observed result word.
    typedef struct {
        logic [EV_W-1:0]    ev;
        logic [TAG_W-1:0]   tg;
        logic [PRIO_W-1:0]  cls;
        logic [LEN_W-1:0]   len;
        logic               s2;
        logic [MOVED_W-1:0] moved;
        logic [S2B_W-1:0]   s2bits;
        logic               lst;
    } result_word_t;

    // One row of the directed table. When has_exp is set, the first result
    // of the row must also equal the typed-in event.
    typedef struct {
        logic [MODE_W-1:0] md;
        logic [PRIO_W-1:0] pr;
        logic [TAG_W-1:0]  tg;
        logic [LEN_W-1:0]  len;
        bit                has_exp;
        logic [EV_W-1:0]   exp_ev;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic [MODE_W-1:0] mode;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  packet_tag;
    logic [LEN_W-1:0]  length_bits;
    logic out_valid;
    logic out_stall;
    logic [EV_W-1:0]    event_res;
    logic [TAG_W-1:0]   tag;
    logic [PRIO_W-1:0]  class_out;
    logic [LEN_W-1:0]   bits;
    logic               was_stage_two;
    logic [MOVED_W-1:0] moved_count;
    logic [S2B_W-1:0]   stage_two_bits;
    logic               last;

    priority_pushout_two_stage_buffer uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .priority_req(priority_req), .packet_tag(packet_tag),
        .length_bits(length_bits), .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .tag(tag), .class_out(class_out), .bits(bits),
        .was_stage_two(was_stage_two), .moved_count(moved_count),
        .stage_two_bits(stage_two_bits), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the buffer state, kept by the predictor.
    logic [TAG_W-1:0]  shadow_tags [NPRI*DEPTH];
    logic [LEN_W-1:0]  shadow_lens [NPRI*DEPTH];
    int unsigned       shadow_head [NPRI];
    int unsigned       shadow_count [NPRI];
    longint unsigned   shadow_bits [NPRI];
    int unsigned       shadow_s2cnt [NPRI];
    longint unsigned   shadow_s2bits [NPRI];
    longint unsigned   shadow_size;

    result_word_t pending_results[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  long_hold;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic result_word_t make_word(logic [EV_W-1:0] ev, logic [TAG_W-1:0] tg,
                                               logic [PRIO_W-1:0] cls, logic [LEN_W-1:0] len,
                                               logic s2, logic [MOVED_W-1:0] moved,
                                               longint unsigned s2b);
        result_word_t w;
        w.ev = ev; w.tg = tg; w.cls = cls; w.len = len; w.s2 = s2;
        w.moved = moved; w.s2bits = s2b[S2B_W-1:0]; w.lst = 1'b0;
        return w;
    endfunction

    // Appends one expected word at the tail of the queue.
    function automatic void queue_result(result_word_t w);
        pending_results.insert(pending_results.size(), w);
    endfunction

    // Removes the front entry of a class and queues its report.
    function automatic void take_front(int unsigned c, logic [EV_W-1:0] ev);
        int unsigned slot;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tg;
        logic s2;
        slot = c * DEPTH + shadow_head[c];
        tg = shadow_tags[slot];
        len = shadow_lens[slot];
        s2 = 1'b0;
        if (shadow_s2cnt[c] > 0)
        begin
            s2 = 1'b1;
            shadow_s2cnt[c]--;
            shadow_s2bits[c] -= len;
        end
        shadow_head[c] = (shadow_head[c] + 1) % DEPTH;
        shadow_count[c]--;
        shadow_bits[c] -= len;
        queue_result(make_word(ev, tg, c[PRIO_W-1:0], len, s2, '0, shadow_s2bits[c]));
    endfunction

    // Works out every result word caused by one accepted input word.
    function automatic void predict_buffer(logic [MODE_W-1:0] md, logic [PRIO_W-1:0] pr,
                                           logic [TAG_W-1:0] tg, logic [LEN_W-1:0] len);
        longint unsigned total;
        longint unsigned below;
        int victim;
        int pick;
        int unsigned slot;
        int unsigned moved;
        logic [PRIO_W-1:0] cls;
        if (md == MODE_INSERT)
        begin
            if (pr < NPRI)
            begin
                forever
                begin
                    total = 0;
                    below = 0;
                    victim = -1;
                    for (int c = 0; c < NPRI; c++)
                    begin
                        total += shadow_bits[c];
                        if (c >= pr)
                        begin
                            below += shadow_bits[c];
                            if (shadow_count[c] > 0)
                                victim = c;
                        end
                    end
                    if (!(total + len > shadow_size && below >= len))
                        break;
                    if (victim < 0)
                        break;
                    take_front(victim, EV_DROPPED);
                end
                if (shadow_count[pr] < DEPTH)
                begin
                    slot = pr * DEPTH + (shadow_head[pr] + shadow_count[pr]) % DEPTH;
                    shadow_tags[slot] = tg;
                    shadow_lens[slot] = len;
                    shadow_count[pr]++;
                    shadow_bits[pr] += len;
                    queue_result(make_word(EV_ACCEPTED, tg, pr, len, 1'b0, '0,
                                           shadow_s2bits[pr]));
                end
                else
                    queue_result(make_word(EV_REJECTED, tg, pr, len, 1'b0, '0,
                                           shadow_s2bits[pr]));
            end
            else
                queue_result(make_word(EV_REJECTED, tg, pr, len, 1'b0, '0, 0));
        end
        else if (md == MODE_FORWARD)
        begin
            if (pr < NPRI)
            begin
                moved = shadow_count[pr] - shadow_s2cnt[pr];
                shadow_s2cnt[pr] = shadow_count[pr];
                shadow_s2bits[pr] = shadow_bits[pr];
                queue_result(make_word(EV_FORWARDED, '0, pr, '0, 1'b0,
                                       moved[MOVED_W-1:0], shadow_s2bits[pr]));
            end
            else
                queue_result(make_word(EV_FORWARDED, '0, pr, '0, 1'b0, '0, 0));
        end
        else
        begin
            pick = -1;
            if (md == MODE_POP_ANY)
            begin
                for (int c = 0; c < NPRI && pick < 0; c++)
                    if (shadow_s2cnt[c] > 0)
                        pick = c;
                for (int c = 0; c < NPRI && pick < 0; c++)
                    if (shadow_count[c] > 0)
                        pick = c;
            end
            else if (pr < NPRI && shadow_count[pr] > 0)
                pick = int'(pr);
            if (pick >= 0)
                take_front(pick, EV_POPPED);
            else
            begin
                cls = (md == MODE_POP_GIVEN) ? pr : '0;
                queue_result(make_word(EV_NOTHING, '0, cls, '0, 1'b0, '0,
                                       (cls < NPRI) ? shadow_s2bits[cls] : 0));
            end
        end
        // The final word of every input word carries the last flag.
        pending_results[pending_results.size() - 1].lst = 1'b1;
    endfunction

    // Offers one word and holds it until the block takes it, predicting on
    // the accepting edge. Gaps before the offer follow send_idle_pct; valid
    // drops only for a gap, so a word may follow another with none.
    task automatic send_word(logic [MODE_W-1:0] md, logic [PRIO_W-1:0] pr,
                             logic [TAG_W-1:0] tg, logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        priority_req <= pr;
        packet_tag <= tg;
        length_bits <= len;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_buffer(md, pr, tg, len);
        @(negedge clk);
    endtask

    // Waits until every expected word has come back, then lets the block
    // finish any internal work before the next register write.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_size(longint unsigned value);
        cfg_we <= 1'b1;
        cfg_wdata <= value[SIZE_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_size = value[SIZE_W-1:0];
    endtask

    // Receiver: stalls at random, with one long hold-off on request, and
    // checks each accepted result word against the oldest expectation.
    initial
    begin
        int hold_cycles;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word, event", event_res, -1);
            else
            begin
                want = pending_results.pop_front();
                if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
                if (tag !== want.tg) report_mismatch("tag", tag, want.tg);
                if (class_out !== want.cls) report_mismatch("class_out", class_out, want.cls);
                if (bits !== want.len) report_mismatch("bits", bits, want.len);
                if (was_stage_two !== want.s2)
                    report_mismatch("was_stage_two", was_stage_two, want.s2);
                if (moved_count !== want.moved)
                    report_mismatch("moved_count", moved_count, want.moved);
                if (stage_two_bits !== want.s2bits)
                    report_mismatch("stage_two_bits", stage_two_bits, want.s2bits);
                if (last !== want.lst) report_mismatch("last", last, want.lst);
            end
        end
    end

    // Random word: mostly inserts with a spread of pops and forwards, small
    // lengths so push-out happens against small buffer sizes, and now and
    // then an out-of-range class or an extreme length.
    task automatic send_random_word();
        logic [MODE_W-1:0] md;
        logic [PRIO_W-1:0] pr;
        logic [LEN_W-1:0]  len;
        int r;
        r = $urandom_range(99);
        md = (r < 50) ? MODE_INSERT : (r < 62) ? MODE_FORWARD :
             (r < 81) ? MODE_POP_ANY : MODE_POP_GIVEN;
        pr = ($urandom_range(19) == 0) ? 2'd3 : PRIO_W'($urandom_range(2));
        len = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(300));
        send_word(md, pr, TAG_W'($urandom), len);
    endtask

    stim_row_t directed[$];
    logic [EV_W-1:0] first_ev;

    initial
    begin
        int unsigned sizes[5];
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        mode = MODE_INSERT;
        priority_req = '0;
        packet_tag = '0;
        length_bits = '0;
        shadow_size = BUFFER_SIZE_RESET;
        for (int c = 0; c < NPRI; c++)
        begin
            shadow_head[c] = 0; shadow_count[c] = 0; shadow_bits[c] = 0;
            shadow_s2cnt[c] = 0; shadow_s2bits[c] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table. Only the first rows have a typed-in event: they run
        // first after reset, while the buffer holds at most one entry.
        directed = '{
            '{MODE_POP_ANY,   2'd0, 16'h0000, 16'h0000, 1, EV_NOTHING},
            '{MODE_POP_GIVEN, 2'd2, 16'h0000, 16'h0000, 1, EV_NOTHING},
            '{MODE_POP_GIVEN, 2'd3, 16'h0000, 16'h0000, 1, EV_NOTHING},
            '{MODE_INSERT,    2'd3, 16'hFFFF, 16'hFFFF, 1, EV_REJECTED},
            '{MODE_FORWARD,   2'd3, 16'h0000, 16'h0000, 1, EV_FORWARDED},
            '{MODE_INSERT,    2'd0, 16'hFFFF, 16'hFFFF, 1, EV_ACCEPTED},
            '{MODE_INSERT,    2'd2, 16'h0000, 16'h0000, 1, EV_ACCEPTED},
            '{MODE_INSERT,    2'd1, 16'h1234, 16'h8000, 0, EV_ACCEPTED},
            '{MODE_FORWARD,   2'd1, 16'h0000, 16'h0000, 0, EV_ACCEPTED},
            '{MODE_INSERT,    2'd1, 16'h5678, 16'h0001, 0, EV_ACCEPTED},
            '{MODE_POP_ANY,   2'd0, 16'h0000, 16'h0000, 0, EV_ACCEPTED},
            '{MODE_POP_GIVEN, 2'd0, 16'h0000, 16'h0000, 0, EV_ACCEPTED},
            '{MODE_POP_ANY,   2'd0, 16'h0000, 16'h0000, 0, EV_ACCEPTED},
            '{MODE_POP_ANY,   2'd0, 16'h0000, 16'h0000, 0, EV_ACCEPTED}
        };
        foreach (directed[i])
        begin
            send_word(directed[i].md, directed[i].pr, directed[i].tg, directed[i].len);
            first_ev = pending_results[0].ev;
            if (directed[i].has_exp && first_ev !== directed[i].exp_ev)
                report_mismatch("directed table event", first_ev, directed[i].exp_ev);
            wait_drained();
        end

        // A zero-size buffer: every insert pushes out until nothing is left
        // in range, including the zero-length case with no drop candidate.
        write_size(0);
        for (int i = 0; i < 18; i++)
            send_word(MODE_INSERT, 2'd2, TAG_W'(i), (i == 0) ? 16'd0 : 16'd5);
        send_word(MODE_INSERT, 2'd0, 16'hAAAA, 16'd0);
        send_word(MODE_INSERT, 2'd0, 16'hBBBB, 16'd7);
        wait_drained();

        // Fill one class past its depth so the full-queue rejection shows.
        write_size(32'hFFFF_FFFF);
        for (int i = 0; i < 18; i++)
            send_word(MODE_INSERT, 2'd1, TAG_W'(16'h0100 + i), 16'd3);
        wait_drained();

        // Random phases over several sizes and idling styles.
        sizes = '{600, 2000, 0, 32'hFFFF_FFFF, 1048576};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_size(sizes[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // In the last phase the receiver holds off for a long stretch
            // while the sender keeps offering words, so the block backs up.
            if (ph == 4)
                long_hold = 1'b1;
            for (int i = 0; i < 84; i++)
            begin
                send_random_word();
                // Halfway through each phase the sender pauses until all results are in.
                if (i == 42)
                    wait_drained();
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
